/* rtl/termcap_field_parser_top_macros.svh */
`ifndef TERMCAP_FIELD_PARSER_TOP_MACROS_SVH
`define TERMCAP_FIELD_PARSER_TOP_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define TFP_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that a condition leads to another in the next cycle.
`define TFP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/tfp_pkg.sv */
`default_nettype none

package tfp_pkg;

  typedef enum logic [2:0] {
    REC_NUM    = 3'd0,
    REC_FLAG   = 3'd1,
    REC_SBYTE  = 3'd2,
    REC_SEND   = 3'd3,
    REC_CANCEL = 3'd4
  } rec_kind_t;

  typedef enum logic [9:0] {
    PH_SKIP     = 10'b00_0000_0001,
    PH_FIELD    = 10'b00_0000_0010,
    PH_NAME1    = 10'b00_0000_0100,
    PH_AFTER    = 10'b00_0000_1000,
    PH_NUMFIRST = 10'b00_0001_0000,
    PH_NUM      = 10'b00_0010_0000,
    PH_STR      = 10'b00_0100_0000,
    PH_CARET    = 10'b00_1000_0000,
    PH_BSL      = 10'b01_0000_0000,
    PH_OCT      = 10'b10_0000_0000
  } phase_t;

  localparam int KIND_W = 3;
  localparam int CHAR_W = 8;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_AT     = 8'h40;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_UPPER_E = 8'h45;
  localparam logic [7:0] CH_LOWER_N = 8'h6E;
  localparam logic [7:0] CH_LOWER_R = 8'h72;
  localparam logic [7:0] CH_LOWER_T = 8'h74;
  localparam logic [7:0] CH_LOWER_B = 8'h62;
  localparam logic [7:0] CH_LOWER_F = 8'h66;

  localparam logic [7:0] CTRL_MASK = 8'o037;
  localparam logic [7:0] CODE_ESC  = 8'h1B;
  localparam logic [7:0] CODE_LF   = 8'h0A;
  localparam logic [7:0] CODE_CR   = 8'h0D;
  localparam logic [7:0] CODE_TAB  = 8'h09;
  localparam logic [7:0] CODE_BS   = 8'h08;
  localparam logic [7:0] CODE_FF   = 8'h0C;

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= CH_ZERO) && (b <= CH_NINE);
  endfunction

  function automatic logic [7:0] bsl_map(input logic [7:0] b);
    logic [7:0] m;
    case (b)
      CH_UPPER_E: m = CODE_ESC;
      CH_LOWER_N: m = CODE_LF;
      CH_LOWER_R: m = CODE_CR;
      CH_LOWER_T: m = CODE_TAB;
      CH_LOWER_B: m = CODE_BS;
      CH_LOWER_F: m = CODE_FF;
      default:    m = b;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

/* rtl/termcap_field_parser_top.sv */
// Channel   Ports                                   Direction  Handshake
// in        in_entry_byte                           input      in_valid / in_stall
// out       out_record_kind, out_cap_first_char,    output     out_valid / out_stall
//           out_cap_second_char, out_record_value,
//           out_number_saturated
//
// One byte is taken every cycle while in_stall is low; its result is pushed to the buffer with it.
// A second result from one byte (octal escape closed on a record byte) waits in a one-record
// hold; while a result is held, each byte pushes the held one out and holds its own.
// in_stall rises only when both the output register and its skid stage are full.
// rst_n is synchronous: it returns the parser to the terminal-name field and empties all buffers.
`default_nettype none

module termcap_field_parser_top
  import tfp_pkg::*;
#(
  parameter int VALUE_WIDTH = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic [7:0]             in_entry_byte,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic [2:0]                  out_record_kind,
  output logic [7:0]                  out_cap_first_char,
  output logic [7:0]                  out_cap_second_char,
  output logic [VALUE_WIDTH-1:0]      out_record_value,
  output logic                        out_number_saturated
);

  localparam int REC_W = KIND_W + 2 * CHAR_W + VALUE_WIDTH + 1;

  logic             acc;
  logic             rec_valid;
  logic [REC_W-1:0] rec_data;
  logic [REC_W-1:0] out_data;
  logic             buf_full;

  assign in_stall = buf_full;
  assign acc      = in_valid && !buf_full;

  tfp_core #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (acc),
    .entry_byte(in_entry_byte),
    .rec_valid (rec_valid),
    .rec_data  (rec_data)
  );

  tfp_outbuf #(
    .DATA_WIDTH(REC_W)
  ) u_outbuf (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (acc && rec_valid),
    .push_data(rec_data),
    .full     (buf_full),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  assign out_record_kind      = out_data[REC_W-1 -: KIND_W];
  assign out_cap_first_char   = out_data[REC_W-KIND_W-1 -: CHAR_W];
  assign out_cap_second_char  = out_data[REC_W-KIND_W-CHAR_W-1 -: CHAR_W];
  assign out_record_value     = out_data[VALUE_WIDTH:1];
  assign out_number_saturated = out_data[0];

endmodule

`default_nettype wire

/* rtl/tfp_core.sv */
`default_nettype none

module tfp_core
  import tfp_pkg::*;
#(
  parameter int VALUE_WIDTH = 16,
  localparam int REC_W = KIND_W + 2 * CHAR_W + VALUE_WIDTH + 1
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             acc,
  input  wire logic [7:0]       entry_byte,
  output logic                  rec_valid,
  output logic [REC_W-1:0]      rec_data
);

  localparam int SUM_W = VALUE_WIDTH + 4;

  phase_t                  ph_r, ph_nxt;
  logic [7:0]              n1_r, n1_nxt;
  logic [7:0]              n2_r, n2_nxt;
  logic [VALUE_WIDTH-1:0]  num_r, num_nxt;
  logic                    oct_r, oct_nxt;
  logic                    clamp_r, clamp_nxt;
  logic [7:0]              esc_r, esc_nxt;
  logic [1:0]              left_r, left_nxt;
  logic                    held_v_r, held_v_nxt;
  logic [REC_W-1:0]        held_r, held_nxt;

  logic [7:0]              digit;
  logic                    dig_ok;
  logic                    base8;
  logic [SUM_W-1:0]        mul8, mul10, num_sum;
  logic                    ovf;

  logic                    sb_emit;
  rec_kind_t               sb_kind;
  phase_t                  sb_ph;
  logic                    sb_end;

  logic                    f0_v, f1_v, f0_sat, ent_end;
  rec_kind_t               f0_kind, f1_kind;
  logic [VALUE_WIDTH-1:0]  f0_val;
  logic [7:0]              f1_byte;
  logic [REC_W-1:0]        f0_data, f1_data;

  assign digit  = entry_byte - CH_ZERO;
  assign dig_ok = is_digit(entry_byte);
  assign base8  = (ph_r == PH_NUMFIRST) ? (entry_byte == CH_ZERO) : oct_r;
  assign mul8   = {1'b0, num_r, 3'b000};
  assign mul10  = {1'b0, num_r, 3'b000} + {3'b000, num_r, 1'b0};
  assign num_sum = (base8 ? mul8 : mul10) + SUM_W'(digit[3:0]);
  assign ovf    = |num_sum[SUM_W-1:VALUE_WIDTH];

  always_comb begin
    sb_emit = 1'b0;
    sb_kind = REC_SBYTE;
    sb_ph   = PH_STR;
    sb_end  = 1'b0;
    if (entry_byte == CH_NUL) begin
      sb_emit = 1'b1;
      sb_kind = REC_SEND;
      sb_end  = 1'b1;
    end else if (entry_byte == CH_COLON) begin
      sb_emit = 1'b1;
      sb_kind = REC_SEND;
      sb_ph   = PH_FIELD;
    end else if (entry_byte == CH_CARET) begin
      sb_ph = PH_CARET;
    end else if (entry_byte == CH_BSLASH) begin
      sb_ph = PH_BSL;
    end else begin
      sb_emit = 1'b1;
    end
  end

  always_comb begin
    ph_nxt    = ph_r;
    n1_nxt    = n1_r;
    n2_nxt    = n2_r;
    num_nxt   = num_r;
    oct_nxt   = oct_r;
    clamp_nxt = clamp_r;
    esc_nxt   = esc_r;
    left_nxt  = left_r;
    f0_v      = 1'b0;
    f0_kind   = REC_NUM;
    f0_val    = '0;
    f0_sat    = 1'b0;
    f1_v      = 1'b0;
    f1_kind   = REC_SBYTE;
    f1_byte   = 8'h00;
    ent_end   = 1'b0;
    case (ph_r)
      PH_FIELD: begin
        if (entry_byte == CH_NUL) begin
          ent_end = 1'b1;
        end else if (entry_byte != CH_COLON) begin
          n1_nxt = entry_byte;
          ph_nxt = PH_NAME1;
        end
      end
      PH_NAME1: begin
        if (entry_byte == CH_NUL) begin
          ent_end = 1'b1;
        end else if (entry_byte == CH_COLON) begin
          ph_nxt = PH_FIELD;
        end else begin
          n2_nxt = entry_byte;
          ph_nxt = PH_AFTER;
        end
      end
      PH_AFTER: begin
        if (entry_byte == CH_AT) begin
          f0_v    = 1'b1;
          f0_kind = REC_CANCEL;
          ph_nxt  = PH_SKIP;
        end else if (entry_byte == CH_HASH) begin
          num_nxt   = '0;
          clamp_nxt = 1'b0;
          oct_nxt   = 1'b0;
          ph_nxt    = PH_NUMFIRST;
        end else if (entry_byte == CH_COLON) begin
          f0_v    = 1'b1;
          f0_kind = REC_FLAG;
          ph_nxt  = PH_FIELD;
        end else if (entry_byte == CH_NUL) begin
          f0_v    = 1'b1;
          f0_kind = REC_FLAG;
          ent_end = 1'b1;
        end else if (entry_byte == CH_EQ) begin
          ph_nxt = PH_STR;
        end else begin
          ph_nxt = PH_SKIP;
        end
      end
      PH_NUMFIRST, PH_NUM: begin
        if (ph_r == PH_NUMFIRST) begin
          oct_nxt = (entry_byte == CH_ZERO);
        end
        if (dig_ok) begin
          num_nxt   = ovf ? '1 : num_sum[VALUE_WIDTH-1:0];
          clamp_nxt = clamp_r | ovf;
          ph_nxt    = PH_NUM;
        end else begin
          f0_v    = 1'b1;
          f0_kind = REC_NUM;
          f0_val  = num_r;
          f0_sat  = clamp_r;
          if (entry_byte == CH_NUL) begin
            ent_end = 1'b1;
          end else if (entry_byte == CH_COLON) begin
            ph_nxt = PH_FIELD;
          end else begin
            ph_nxt = PH_SKIP;
          end
        end
      end
      PH_STR: begin
        f0_v    = sb_emit;
        f0_kind = sb_kind;
        f0_val  = (sb_kind == REC_SBYTE) ? VALUE_WIDTH'(entry_byte) : '0;
        ph_nxt  = sb_ph;
        ent_end = sb_end;
      end
      PH_CARET: begin
        f0_v = 1'b1;
        if (entry_byte == CH_NUL) begin
          f0_kind = REC_SEND;
          ent_end = 1'b1;
        end else begin
          f0_kind = REC_SBYTE;
          f0_val  = VALUE_WIDTH'(entry_byte & CTRL_MASK);
          ph_nxt  = PH_STR;
        end
      end
      PH_BSL: begin
        if (entry_byte == CH_NUL) begin
          f0_v    = 1'b1;
          f0_kind = REC_SEND;
          ent_end = 1'b1;
        end else if (dig_ok) begin
          esc_nxt  = digit;
          left_nxt = 2'd2;
          ph_nxt   = PH_OCT;
        end else begin
          f0_v    = 1'b1;
          f0_kind = REC_SBYTE;
          f0_val  = VALUE_WIDTH'(bsl_map(entry_byte));
          ph_nxt  = PH_STR;
        end
      end
      PH_OCT: begin
        if (entry_byte == CH_NUL) begin
          f0_v    = 1'b1;
          f0_kind = REC_SEND;
          ent_end = 1'b1;
        end else if (left_r >= 2'd2) begin
          esc_nxt  = {esc_r[4:0], 3'b000} | digit;
          left_nxt = 2'd1;
        end else if (dig_ok) begin
          esc_nxt  = {esc_r[4:0], 3'b000} | digit;
          left_nxt = 2'd0;
          f0_v     = 1'b1;
          f0_kind  = REC_SBYTE;
          f0_val   = VALUE_WIDTH'({esc_r[4:0], 3'b000} | digit);
          ph_nxt   = PH_STR;
        end else begin
          left_nxt = 2'd0;
          f0_v     = 1'b1;
          f0_kind  = REC_SBYTE;
          f0_val   = VALUE_WIDTH'(esc_r);
          f1_v     = sb_emit;
          f1_kind  = sb_kind;
          f1_byte  = (sb_kind == REC_SBYTE) ? entry_byte : 8'h00;
          ph_nxt   = sb_ph;
          ent_end  = sb_end;
        end
      end
      default: begin
        if (entry_byte == CH_NUL) begin
          ent_end = 1'b1;
        end else if (entry_byte == CH_COLON) begin
          ph_nxt = PH_FIELD;
        end else begin
          ph_nxt = PH_SKIP;
        end
      end
    endcase
    if (ent_end) begin
      ph_nxt    = PH_SKIP;
      n1_nxt    = 8'h00;
      n2_nxt    = 8'h00;
      num_nxt   = '0;
      oct_nxt   = 1'b0;
      clamp_nxt = 1'b0;
      esc_nxt   = 8'h00;
      left_nxt  = 2'd0;
    end
  end

  assign f0_data = {f0_kind, n1_r, n2_r, f0_val, f0_sat};
  assign f1_data = {f1_kind, n1_r, n2_r, VALUE_WIDTH'(f1_byte), 1'b0};

  always_comb begin
    rec_valid  = held_v_r | f0_v;
    rec_data   = held_v_r ? held_r : f0_data;
    held_v_nxt = held_v_r ? f0_v : f1_v;
    held_nxt   = held_v_r ? f0_data : f1_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r     <= PH_SKIP;
      n1_r     <= 8'h00;
      n2_r     <= 8'h00;
      num_r    <= '0;
      oct_r    <= 1'b0;
      clamp_r  <= 1'b0;
      esc_r    <= 8'h00;
      left_r   <= 2'd0;
      held_v_r <= 1'b0;
    end else if (acc) begin
      ph_r     <= ph_nxt;
      n1_r     <= n1_nxt;
      n2_r     <= n2_nxt;
      num_r    <= num_nxt;
      oct_r    <= oct_nxt;
      clamp_r  <= clamp_nxt;
      esc_r    <= esc_nxt;
      left_r   <= left_nxt;
      held_v_r <= held_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      held_r <= held_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/tfp_outbuf.sv */
`default_nettype none

`include "termcap_field_parser_top_macros.svh"

module tfp_outbuf
  import tfp_pkg::*;
#(
  parameter int DATA_WIDTH = 36
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  push,
  input  wire logic [DATA_WIDTH-1:0] push_data,
  output logic                       full,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [DATA_WIDTH-1:0]      out_data
);

  logic                  main_v_r, main_v_nxt;
  logic                  skid_v_r, skid_v_nxt;
  logic [DATA_WIDTH-1:0] main_r, main_nxt;
  logic [DATA_WIDTH-1:0] skid_r, skid_nxt;
  logic                  pop;

  assign pop       = main_v_r && !out_stall;
  assign full      = skid_v_r;
  assign out_valid = main_v_r;
  assign out_data  = main_r;

  always_comb begin
    main_v_nxt = main_v_r;
    skid_v_nxt = skid_v_r;
    main_nxt   = main_r;
    skid_nxt   = skid_r;
    if (skid_v_r) begin
      if (pop) begin
        main_nxt   = skid_r;
        skid_v_nxt = 1'b0;
      end
    end else if (push) begin
      if (!main_v_r || pop) begin
        main_nxt   = push_data;
        main_v_nxt = 1'b1;
      end else begin
        skid_nxt   = push_data;
        skid_v_nxt = 1'b1;
      end
    end else if (pop) begin
      main_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      main_v_r <= main_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

  `TFP_ASSERT_ALWAYS(a_skid_behind_main, !skid_v_r || main_v_r, "skid holds a request with main empty")
  `TFP_ASSERT_ALWAYS(a_no_push_when_full, !(push && skid_v_r), "request pushed into full buffer")
  `TFP_ASSERT_NEXT(a_skid_drains, skid_v_r && !out_stall, !skid_v_r, "skid did not drain on pop")
  `TFP_ASSERT_NEXT(a_stalled_push_to_skid, push && main_v_r && out_stall, skid_v_r, "stalled request lost")

endmodule

`default_nettype wire

/* bench/tb_termcap_field_parser_top.sv */
module tb_termcap_field_parser_top;
  import tfp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int VALUE_W = 16;
  localparam logic [31:0] VALUE_MAX = (32'd1 << VALUE_W) - 32'd1;
  localparam int DIR_ROWS = 29;
  localparam int RANDOM_REQS = 1000;
  localparam int HOLDOFF_CYCLES = 60;
  localparam int MAX_PRINTS = 30;

  typedef enum logic [1:0] {
    WANT_MODEL = 2'd0,
    WANT_NONE  = 2'd1,
    WANT_REC   = 2'd2
  } want_t;

  typedef struct packed {
    rec_kind_t          kind;
    logic [7:0]         c1;
    logic [7:0]         c2;
    logic [VALUE_W-1:0] value;
    logic               sat;
  } cap_rec_t;

  typedef struct packed {
    want_t      want;
    logic [7:0] b;
    cap_rec_t   rec;
  } req_t;

  localparam cap_rec_t NO_REC = '0;

  localparam req_t DIR_TABLE [0:DIR_ROWS-1] = '{
    '{WANT_NONE,  "x",       NO_REC},
    '{WANT_NONE,  CH_COLON,  NO_REC},
    '{WANT_NONE,  CH_COLON,  NO_REC},
    '{WANT_NONE,  "c",       NO_REC},
    '{WANT_NONE,  "o",       NO_REC},
    '{WANT_NONE,  CH_HASH,   NO_REC},
    '{WANT_NONE,  "9",       NO_REC},
    '{WANT_NONE,  "9",       NO_REC},
    '{WANT_NONE,  "9",       NO_REC},
    '{WANT_NONE,  "9",       NO_REC},
    '{WANT_NONE,  "9",       NO_REC},
    '{WANT_REC,   CH_COLON,  '{REC_NUM, "c", "o", 16'hFFFF, 1'b1}},
    '{WANT_NONE,  "a",       NO_REC},
    '{WANT_NONE,  "m",       NO_REC},
    '{WANT_REC,   CH_COLON,  '{REC_FLAG, "a", "m", 16'h0000, 1'b0}},
    '{WANT_NONE,  "k",       NO_REC},
    '{WANT_NONE,  8'hFF,     NO_REC},
    '{WANT_REC,   CH_AT,     '{REC_CANCEL, "k", 8'hFF, 16'h0000, 1'b0}},
    '{WANT_NONE,  CH_COLON,  NO_REC},
    '{WANT_NONE,  "s",       NO_REC},
    '{WANT_NONE,  "e",       NO_REC},
    '{WANT_NONE,  CH_EQ,     NO_REC},
    '{WANT_NONE,  CH_CARET,  NO_REC},
    '{WANT_MODEL, "A",       NO_REC},
    '{WANT_NONE,  CH_BSLASH, NO_REC},
    '{WANT_NONE,  "1",       NO_REC},
    '{WANT_NONE,  "2",       NO_REC},
    '{WANT_MODEL, CH_COLON,  NO_REC},
    '{WANT_MODEL, CH_NUL,    NO_REC}
  };

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [7:0]         in_entry_byte = 8'h00;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [2:0]         out_record_kind;
  logic [7:0]         out_cap_first_char;
  logic [7:0]         out_cap_second_char;
  logic [VALUE_W-1:0] out_record_value;
  logic               out_number_saturated;

  termcap_field_parser_top #(.VALUE_WIDTH(VALUE_W)) dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_entry_byte        (in_entry_byte),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_record_kind      (out_record_kind),
    .out_cap_first_char   (out_cap_first_char),
    .out_cap_second_char  (out_cap_second_char),
    .out_record_value     (out_record_value),
    .out_number_saturated (out_number_saturated)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #400_000;
    $display("termcap_field_parser_top verification failed");
    $finish;
  end

  // parser state mirror
  phase_t       ph = PH_SKIP;
  logic [7:0]   cap_c1 = '0;
  logic [7:0]   cap_c2 = '0;
  logic [15:0]  num_acc = '0;
  logic         num_octal = 1'b0;
  logic         num_clamped = 1'b0;
  logic [7:0]   esc_acc = '0;
  logic [1:0]   esc_left = '0;
  logic         held_ok = 1'b0;
  cap_rec_t     held_rec = '0;
  cap_rec_t     fresh [2];
  int           nfresh;

  cap_rec_t     pending_records [$];
  req_t         stim_q [$];
  req_t         cur_req = '0;

  int           send_idle = 0;
  int           recv_idle = 0;
  logic         hold_req = 1'b0;
  int           errors = 0;
  int           bytes_taken = 0;
  int           entry_ends = 0;
  int           records_seen = 0;
  int           clamped_seen = 0;
  int           kind_count [5] = '{default: 0};

  function automatic logic digit_char(input logic [7:0] b);
    return (b >= CH_ZERO) && (b <= CH_NINE);
  endfunction

  function automatic void add_fresh(input rec_kind_t kind, input logic [15:0] val,
                                    input logic sat);
    if (nfresh < 2) begin
      fresh[nfresh] = '{kind, cap_c1, cap_c2, val, sat};
      nfresh++;
    end
  endfunction

  function automatic void clear_entry();
    ph = PH_SKIP;
    cap_c1 = '0;
    cap_c2 = '0;
    num_acc = '0;
    num_octal = 1'b0;
    num_clamped = 1'b0;
    esc_acc = '0;
    esc_left = '0;
  endfunction

  function automatic void string_char(input logic [7:0] b);
    if (b == CH_NUL) begin
      add_fresh(REC_SEND, '0, 1'b0);
      clear_entry();
    end else if (b == CH_COLON) begin
      add_fresh(REC_SEND, '0, 1'b0);
      ph = PH_FIELD;
    end else if (b == CH_CARET) begin
      ph = PH_CARET;
    end else if (b == CH_BSLASH) begin
      ph = PH_BSL;
    end else begin
      add_fresh(REC_SBYTE, {8'h00, b}, 1'b0);
      ph = PH_STR;
    end
  endfunction

  function automatic void number_char(input logic [7:0] b);
    logic [31:0] v;
    if (digit_char(b)) begin
      v = 32'(num_acc) * (num_octal ? 32'd8 : 32'd10) + 32'(b - CH_ZERO);
      if (v > VALUE_MAX) begin
        v = VALUE_MAX;
        num_clamped = 1'b1;
      end
      num_acc = v[15:0];
      ph = PH_NUM;
    end else begin
      add_fresh(REC_NUM, num_acc, num_clamped);
      if (b == CH_NUL) clear_entry();
      else if (b == CH_COLON) ph = PH_FIELD;
      else ph = PH_SKIP;
    end
  endfunction

  function automatic void parse_entry_byte(input logic [7:0] b, output logic has,
                                           output cap_rec_t rec);
    logic [7:0] m;
    nfresh = 0;
    case (ph)
      PH_FIELD: begin
        if (b == CH_NUL) clear_entry();
        else if (b != CH_COLON) begin
          cap_c1 = b;
          ph = PH_NAME1;
        end
      end
      PH_NAME1: begin
        if (b == CH_NUL) clear_entry();
        else if (b == CH_COLON) ph = PH_FIELD;
        else begin
          cap_c2 = b;
          ph = PH_AFTER;
        end
      end
      PH_AFTER: begin
        if (b == CH_AT) begin
          add_fresh(REC_CANCEL, '0, 1'b0);
          ph = PH_SKIP;
        end else if (b == CH_HASH) begin
          num_acc = '0;
          num_clamped = 1'b0;
          num_octal = 1'b0;
          ph = PH_NUMFIRST;
        end else if (b == CH_COLON) begin
          add_fresh(REC_FLAG, '0, 1'b0);
          ph = PH_FIELD;
        end else if (b == CH_NUL) begin
          add_fresh(REC_FLAG, '0, 1'b0);
          clear_entry();
        end else if (b == CH_EQ) begin
          ph = PH_STR;
        end else begin
          ph = PH_SKIP;
        end
      end
      PH_NUMFIRST: begin
        num_octal = (b == CH_ZERO);
        number_char(b);
      end
      PH_NUM: number_char(b);
      PH_STR: string_char(b);
      PH_CARET: begin
        if (b == CH_NUL) begin
          add_fresh(REC_SEND, '0, 1'b0);
          clear_entry();
        end else begin
          add_fresh(REC_SBYTE, {8'h00, b & CTRL_MASK}, 1'b0);
          ph = PH_STR;
        end
      end
      PH_BSL: begin
        if (b == CH_NUL) begin
          add_fresh(REC_SEND, '0, 1'b0);
          clear_entry();
        end else if (digit_char(b)) begin
          esc_acc = b - CH_ZERO;
          esc_left = 2'd2;
          ph = PH_OCT;
        end else begin
          case (b)
            CH_UPPER_E: m = CODE_ESC;
            CH_LOWER_N: m = CODE_LF;
            CH_LOWER_R: m = CODE_CR;
            CH_LOWER_T: m = CODE_TAB;
            CH_LOWER_B: m = CODE_BS;
            CH_LOWER_F: m = CODE_FF;
            default:    m = b;
          endcase
          add_fresh(REC_SBYTE, {8'h00, m}, 1'b0);
          ph = PH_STR;
        end
      end
      PH_OCT: begin
        if (b == CH_NUL) begin
          add_fresh(REC_SEND, '0, 1'b0);
          clear_entry();
        end else if (esc_left >= 2'd2) begin
          esc_acc = {esc_acc[4:0], 3'b000} | 8'(b - CH_ZERO);
          esc_left = 2'd1;
        end else if (digit_char(b)) begin
          esc_acc = {esc_acc[4:0], 3'b000} | 8'(b - CH_ZERO);
          esc_left = 2'd0;
          add_fresh(REC_SBYTE, {8'h00, esc_acc}, 1'b0);
          ph = PH_STR;
        end else begin
          esc_left = 2'd0;
          add_fresh(REC_SBYTE, {8'h00, esc_acc}, 1'b0);
          string_char(b);
        end
      end
      default: begin
        if (b == CH_NUL) clear_entry();
        else if (b == CH_COLON) ph = PH_FIELD;
        else ph = PH_SKIP;
      end
    endcase

    // a held record goes out first; one fresh record may take its place
    has = 1'b0;
    rec = '0;
    if (held_ok) begin
      rec = held_rec;
      has = 1'b1;
      held_ok = 1'b0;
      if (nfresh >= 1) begin
        held_rec = fresh[0];
        held_ok = 1'b1;
      end
    end else if (nfresh >= 1) begin
      rec = fresh[0];
      has = 1'b1;
      if (nfresh == 2) begin
        held_rec = fresh[1];
        held_ok = 1'b1;
      end
    end
  endfunction

  function automatic void put(input logic [7:0] b);
    req_t r;
    r = '0;
    r.want = WANT_MODEL;
    r.b = b;
    stim_q.push_back(r);
  endfunction

  function automatic logic [7:0] pick_body_char();
    logic [7:0] c;
    c = 8'($urandom_range(1, 255));
    if (c == CH_COLON) c = "z";
    return c;
  endfunction

  function automatic logic [7:0] pick_name_char();
    if ($urandom_range(0, 3) != 0) return 8'($urandom_range(97, 122));
    return pick_body_char();
  endfunction

  function automatic logic [7:0] pick_digit();
    return 8'(CH_ZERO + 8'($urandom_range(0, 9)));
  endfunction

  function automatic logic [7:0] pick_non_digit();
    logic [7:0] c;
    c = pick_body_char();
    if (digit_char(c)) c = "y";
    return c;
  endfunction

  function automatic void put_name();
    put(pick_name_char());
    put(pick_name_char());
  endfunction

  function automatic bit gen_field();
    int r;
    int n;
    logic [7:0] c;
    r = $urandom_range(0, 99);
    if (r < 15) begin
      put_name();
    end else if (r < 25) begin
      put_name();
      put(CH_AT);
      repeat ($urandom_range(0, 3)) put(pick_body_char());
    end else if (r < 50) begin
      put_name();
      put(CH_HASH);
      if ($urandom_range(0, 2) == 0) put(CH_ZERO);
      n = ($urandom_range(0, 5) == 0) ? $urandom_range(6, 12) : $urandom_range(0, 4);
      repeat (n) put(pick_digit());
      if ($urandom_range(0, 3) == 0) begin
        put(pick_non_digit());
        repeat ($urandom_range(0, 3)) put(pick_body_char());
      end
    end else if (r < 85) begin
      put_name();
      put(CH_EQ);
      repeat ($urandom_range(0, 8)) begin
        case ($urandom_range(0, 4))
          0: begin
            c = pick_body_char();
            if (c == CH_CARET || c == CH_BSLASH) c = "q";
            put(c);
          end
          1: begin
            put(CH_CARET);
            put(8'($urandom_range(1, 255)));
          end
          2: begin
            put(CH_BSLASH);
            case ($urandom_range(0, 9))
              0: put(CH_UPPER_E);
              1: put(CH_CARET);
              2: put(CH_BSLASH);
              3: put(CH_COLON);
              4: put(CH_LOWER_N);
              5: put(CH_LOWER_R);
              6: put(CH_LOWER_T);
              7: put(CH_LOWER_B);
              8: put(CH_LOWER_F);
              default: put(pick_non_digit());
            endcase
          end
          default: begin
            put(CH_BSLASH);
            put(pick_digit());
            put(($urandom_range(0, 3) != 0) ? pick_digit() : 8'($urandom_range(1, 255)));
            if ($urandom_range(0, 1) == 0) put(pick_digit());
          end
        endcase
      end
      // cut the entry inside an escape
      if ($urandom_range(0, 19) == 0) begin
        case ($urandom_range(0, 2))
          0: put(CH_CARET);
          1: put(CH_BSLASH);
          default: begin
            put(CH_BSLASH);
            put(pick_digit());
            if ($urandom_range(0, 1) == 0) put(pick_digit());
          end
        endcase
        put(CH_NUL);
        return 1'b1;
      end
    end else if (r < 92) begin
      if ($urandom_range(0, 1) == 0) put(pick_name_char());
    end else begin
      put_name();
      c = pick_body_char();
      if (c == CH_AT || c == CH_HASH || c == CH_EQ) c = "w";
      put(c);
      repeat ($urandom_range(0, 3)) put(pick_body_char());
    end
    return 1'b0;
  endfunction

  function automatic void gen_entry();
    int k;
    int nf;
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(5, 30)) put(8'($urandom_range(0, 255)));
      put(CH_NUL);
      return;
    end
    repeat ($urandom_range(0, 6)) put(pick_name_char());
    nf = $urandom_range(1, 6);
    for (k = 0; k < nf; k++) begin
      put(CH_COLON);
      if (gen_field()) return;
    end
    put(CH_NUL);
  endfunction

  task automatic report_mismatch(input string what, input longint unsigned seen,
                                 input longint unsigned wanted);
    errors++;
    if (errors <= MAX_PRINTS)
      $display("MISMATCH at %0t: %s seen 0x%0h wanted 0x%0h", $realtime, what, seen, wanted);
  endtask

  always @(posedge clk) begin : monitor
    logic has;
    cap_rec_t pred;
    cap_rec_t exp_rec;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        parse_entry_byte(cur_req.b, has, pred);
        bytes_taken++;
        if (cur_req.b == CH_NUL) entry_ends++;
        case (cur_req.want)
          WANT_MODEL: if (has) pending_records.push_back(pred);
          WANT_REC:   pending_records.push_back(cur_req.rec);
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        records_seen++;
        if (out_record_kind < 3'd5) kind_count[out_record_kind]++;
        if (out_record_kind == REC_NUM && out_number_saturated) clamped_seen++;
        if (pending_records.size() == 0) begin
          report_mismatch("record with nothing pending, kind", out_record_kind, 0);
        end else begin
          exp_rec = pending_records.pop_front();
          if (out_record_kind !== exp_rec.kind)
            report_mismatch("record_kind", out_record_kind, exp_rec.kind);
          if (out_cap_first_char !== exp_rec.c1)
            report_mismatch("cap_first_char", out_cap_first_char, exp_rec.c1);
          if (out_cap_second_char !== exp_rec.c2)
            report_mismatch("cap_second_char", out_cap_second_char, exp_rec.c2);
          if (out_record_value !== exp_rec.value)
            report_mismatch("record_value", out_record_value, exp_rec.value);
          if (out_number_saturated !== exp_rec.sat)
            report_mismatch("number_saturated", out_number_saturated, exp_rec.sat);
        end
      end
    end
  end

  initial begin : receiver
    int hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLDOFF_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(0, 99) < recv_idle);
      end
    end
  end

  task automatic send_request(input req_t r);
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_entry_byte <= r.b;
    cur_req <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain_records();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_records.size() != 0) @(negedge clk);
  endtask

  initial begin : stimulus
    int i;
    int p;
    int first;
    int last;
    int total;
    for (i = 0; i < DIR_ROWS; i++) stim_q.push_back(DIR_TABLE[i]);
    while (stim_q.size() < DIR_ROWS + RANDOM_REQS) gen_entry();
    total = stim_q.size();

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (p = 0; p < 3; p++) begin
      case (p)
        0: begin
          send_idle = 14;
          recv_idle = 56;
        end
        1: begin
          send_idle = 56;
          recv_idle = 14;
        end
        default: begin
          send_idle = 0;
          recv_idle = 0;
          hold_req = 1'b1;
        end
      endcase
      first = p * total / 3;
      last = (p == 2) ? total : (p + 1) * total / 3;
      for (i = first; i < last; i++) send_request(stim_q[i]);
      drain_records();
    end

    repeat (20) @(posedge clk);
    $display("Covered %0d requests over %0d entry ends, %0d records checked",
             bytes_taken, entry_ends, records_seen);
    $display("Records: %0d numbers (%0d clamped), %0d flags, %0d string bytes,",
             kind_count[0], clamped_seen, kind_count[1], kind_count[2]);
    $display("         %0d string ends, %0d cancels", kind_count[3], kind_count[4]);
    if (errors == 0) begin
      $display("termcap_field_parser_top verification clean");
    end else begin
      $display("termcap_field_parser_top verification failed");
    end
    $finish;
  end

endmodule

/* termcap_field_parser_top.f */
+incdir+rtl
rtl/tfp_pkg.sv
rtl/tfp_core.sv
rtl/tfp_outbuf.sv
rtl/termcap_field_parser_top.sv
bench/tb_termcap_field_parser_top.sv
